>>> src/srld_pkg.sv
// shared constants, types and the direction table for the sensor ring line direction block
package srld_pkg;

  localparam int SENSOR_COUNT = 24;
  localparam int MASK_W       = 24;
  localparam int IDX_W        = $clog2(SENSOR_COUNT);
  localparam int GAP_W        = $clog2(SENSOR_COUNT + 1);
  localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
  localparam int HALF_W       = $clog2(4 * SENSOR_COUNT);
  localparam int LUT_DEPTH    = 1 << HALF_W;
  localparam int HALF_RING    = SENSOR_COUNT / 2;

  localparam int DIR_W        = 9;
  localparam int GAP_OUT_W    = 4;
  localparam int CNT_OUT_W    = 5;
  localparam int DIFF_W       = DIR_W + 1;

  localparam int HALF_TURN    = 180;
  localparam int FULL_TURN    = 360;
  localparam int JUMP_LIMIT   = 120;

  // one lane: the gap that ends at this lane's sensor
  typedef struct packed {
    logic             lit;
    logic [GAP_W-1:0] gap;
    logic [IDX_W-1:0] start;
  } lane_t;

  // merged result of all lanes
  typedef struct packed {
    logic             lit;
    logic [GAP_W-1:0] gap;
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] count;
  } best_t;

  typedef logic signed [DIR_W-1:0] dir_lut_t [LUT_DEPTH];

  // index is the angle in half sensor steps plus a half turn
  function automatic dir_lut_t build_dir_lut();
    dir_lut_t lut;
    int       v;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      v = i;
      while (v > SENSOR_COUNT) v = v - 2 * SENSOR_COUNT;
      while (v <= -SENSOR_COUNT) v = v + 2 * SENSOR_COUNT;
      lut[i] = DIR_W'((v * HALF_TURN) / SENSOR_COUNT);
    end
    return lut;
  endfunction

endpackage

>>> src/srld_lane.sv
// one sensor lane: distance back to the previous lit sensor round the ring
module srld_lane
  import srld_pkg::*;
(
  input  logic [IDX_W-1:0]        lane_idx,
  input  logic [SENSOR_COUNT-1:0] rot_mask,
  output lane_t                   res
);

  logic [GAP_W-1:0] back_steps;
  logic [IDX_W:0]   start_raw;

  // rot_mask bit k is the sensor k steps behind this one; bit 0 is this sensor
  always_comb begin
    back_steps = GAP_W'(SENSOR_COUNT);
    for (int k = SENSOR_COUNT - 1; k >= 1; k--) begin
      if (rot_mask[k]) back_steps = GAP_W'(k);
    end
  end

  assign start_raw = (IDX_W + 1)'(lane_idx) + (IDX_W + 1)'(SENSOR_COUNT)
                   - (IDX_W + 1)'(back_steps);

  always_comb begin
    res.lit = rot_mask[0];
    res.gap = back_steps;
    if (start_raw >= (IDX_W + 1)'(SENSOR_COUNT)) begin
      res.start = IDX_W'(start_raw - (IDX_W + 1)'(SENSOR_COUNT));
    end else begin
      res.start = IDX_W'(start_raw);
    end
  end

endmodule

>>> src/srld_merge.sv
// merge stage: widest gap over all lanes by a compare tree, plus lit count
module srld_merge
  import srld_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  lane_t lanes [SENSOR_COUNT],
  output best_t best_r
);

  localparam int LEAVES = 1 << IDX_W;

  lane_t            node [2 * LEAVES - 1];
  logic [CNT_W-1:0] count;
  best_t            best_nxt;

  // wider gap wins, smaller start on a tie
  function automatic lane_t pick(lane_t a, lane_t b);
    lane_t r;
    r = a;
    if (!a.lit) r = b;
    else if (b.lit && (b.gap > a.gap || (b.gap == a.gap && b.start < a.start))) r = b;
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < SENSOR_COUNT) node[LEAVES - 1 + i] = lanes[i];
      else                  node[LEAVES - 1 + i] = '0;
    end
    for (int i = LEAVES - 2; i >= 0; i--) begin
      node[i] = pick(node[2 * i + 1], node[2 * i + 2]);
    end
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      count = count + CNT_W'(lanes[i].lit);
    end
  end

  always_comb begin
    best_nxt.lit   = node[0].lit;
    best_nxt.gap   = node[0].gap;
    best_nxt.start = node[0].start;
    best_nxt.count = count;
  end

  always_ff @(posedge clk) begin
    if (en) best_r <= best_nxt;
  end

endmodule

>>> src/srld_dir.sv
// direction stage: angle lookup, gap folding and the half-out flag state
module srld_dir
  import srld_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  best_t                   best,
  output logic signed [DIR_W-1:0] line_direction,
  output logic [GAP_OUT_W-1:0]    widest_gap,
  output logic                    half_out,
  output logic                    on_line,
  output logic [CNT_OUT_W-1:0]    lit_count
);

  localparam dir_lut_t DirLut = build_dir_lut();

  logic [HALF_W-1:0]        half_idx;
  logic signed [DIR_W-1:0]  dir;
  logic [GAP_W-1:0]         gap_fold;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] mag;
  logic signed [DIFF_W-1:0] mag_short;
  logic                     jump;

  logic signed [DIR_W-1:0]  last_dir_r, last_dir_nxt;
  logic                     last_lit_r, last_lit_nxt;
  logic                     flag_r, flag_nxt;
  logic [GAP_OUT_W-1:0]     gap_r, gap_nxt;
  logic [CNT_OUT_W-1:0]     count_r, count_nxt;

  assign half_idx = HALF_W'(best.start) + HALF_W'(best.start) + HALF_W'(best.gap)
                  + HALF_W'(SENSOR_COUNT);
  assign dir      = DirLut[half_idx];
  assign gap_fold = (best.gap > GAP_W'(HALF_RING)) ? GAP_W'(SENSOR_COUNT) - best.gap : best.gap;

  // jump measured the short way round
  assign diff      = DIFF_W'(dir) - DIFF_W'(last_dir_r);
  assign mag       = (diff < 0) ? -diff : diff;
  assign mag_short = (mag > DIFF_W'(HALF_TURN)) ? DIFF_W'(FULL_TURN) - mag : mag;
  assign jump      = mag_short > DIFF_W'(JUMP_LIMIT);

  always_comb begin
    if (best.lit) begin
      last_dir_nxt = dir;
      last_lit_nxt = 1'b1;
      flag_nxt     = (last_lit_r && jump) ? !flag_r : flag_r;
      gap_nxt      = GAP_OUT_W'(gap_fold);
    end else begin
      last_dir_nxt = '0;
      last_lit_nxt = 1'b0;
      flag_nxt     = 1'b0;
      gap_nxt      = '0;
    end
    count_nxt = CNT_OUT_W'(best.count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dir_r <= '0;
      last_lit_r <= 1'b0;
      flag_r     <= 1'b0;
    end else if (en) begin
      last_dir_r <= last_dir_nxt;
      last_lit_r <= last_lit_nxt;
      flag_r     <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gap_r   <= gap_nxt;
      count_r <= count_nxt;
    end
  end

  assign line_direction = last_dir_r;
  assign widest_gap     = gap_r;
  assign half_out       = flag_r;
  assign on_line        = last_lit_r;
  assign lit_count      = count_r;

endmodule

>>> src/sensor_ring_line_direction.sv
// top level of the sensor ring line direction block
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------------
//  in_     | input     | in_valid/in_stall | white_mask[23:0]
//  out_    | output    | out_valid/out_stall | line_direction, widest_gap, half_out,
//          |           |                   | on_line, lit_count
//
//  three stages: lane registers, merge tree register, direction/state register
//  an accepted mask passes the lane, merge and direction registers in that order before out_valid
//  one transaction per cycle while out_stall is low, the direction stage flag state feeds back per result
//  synchronous active-low reset clears valid bits and the kept direction state
//  a stall on out_ only backs up as far as the first empty stage
module sensor_ring_line_direction
  import srld_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [MASK_W-1:0]       in_white_mask,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DIR_W-1:0] out_line_direction,
  output logic [GAP_OUT_W-1:0]    out_widest_gap,
  output logic                    out_half_out,
  output logic                    out_on_line,
  output logic [CNT_OUT_W-1:0]    out_lit_count
);

  // stage valid bits
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic rdy1, rdy2, rdy3;
  logic en1, en2, en3;

  logic [SENSOR_COUNT-1:0] mask;
  lane_t                   lane_c [SENSOR_COUNT];
  lane_t                   lane_r [SENSOR_COUNT];
  best_t                   best_r;

  // each stage moves when it is empty or its successor moves
  assign rdy3 = !v3_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign en1  = in_valid && rdy1;
  assign en2  = v1_r && rdy2;
  assign en3  = v2_r && rdy3;

  assign in_stall  = !rdy1;
  assign out_valid = v3_r;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // sensors beyond the mask width read as dark, mask bits beyond the ring are dropped
  generate
    for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_mask
      if (i < MASK_W) begin : g_in
        assign mask[i] = in_white_mask[i];
      end else begin : g_pad
        assign mask[i] = 1'b0;
      end
    end
  endgenerate

  // one lane per sensor, each sees the ring rotated to its own position
  generate
    for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
      logic [SENSOR_COUNT-1:0] rot;
      for (genvar k = 0; k < SENSOR_COUNT; k++) begin : g_rot
        assign rot[k] = mask[(i - k + SENSOR_COUNT) % SENSOR_COUNT];
      end
      srld_lane u_lane (
        .lane_idx (IDX_W'(i)),
        .rot_mask (rot),
        .res      (lane_c[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en1) lane_r <= lane_c;
  end

  srld_merge u_merge (
    .clk    (clk),
    .en     (en2),
    .lanes  (lane_r),
    .best_r (best_r)
  );

  // the direction stage state doubles as the output register
  srld_dir u_dir (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en3),
    .best           (best_r),
    .line_direction (out_line_direction),
    .widest_gap     (out_widest_gap),
    .half_out       (out_half_out),
    .on_line        (out_on_line),
    .lit_count      (out_lit_count)
  );

endmodule

>>> src/srld_checker.sv
// port-level checker for the sensor ring line direction block, with its bind
module srld_checker
  import srld_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [DIR_W-1:0] out_line_direction,
  input logic [GAP_OUT_W-1:0]    out_widest_gap,
  input logic                    out_half_out,
  input logic                    out_on_line,
  input logic [CNT_OUT_W-1:0]    out_lit_count
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_direction)
      && $stable(out_widest_gap) && $stable(out_half_out) && $stable(out_on_line)
      && $stable(out_lit_count))
    else $error("result changed while stalled");

  // empty frame clears every field
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_on_line |-> out_line_direction == 0 && out_widest_gap == 0
      && !out_half_out && out_lit_count == 0)
    else $error("empty frame left a field set");

  // on_line agrees with the lit count, and a single sensor has no folded gap
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_on_line == (out_lit_count != 0))
      && (out_lit_count != 1 || out_widest_gap == 0))
    else $error("lit count inconsistent");

  // direction is never -180, the open end of (-180,180], and the gap is folded
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_direction != -9'sd180 && out_widest_gap <= 4'(HALF_RING))
    else $error("direction or gap out of range");

endmodule

bind sensor_ring_line_direction srld_checker u_srld_checker (.*);
